### sv/mtrr_pkg.sv
// package: constants, types and helpers for the ranged mt19937 generator
`default_nettype none
package mtrr_pkg;
	localparam int STATE_WORDS = 624;
	localparam int IDX_W = 10;
	localparam int SHIFT_SPAN = 397;
	localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
	localparam logic [31:0] TW_UPPER = 32'h8000_0000;
	localparam logic [31:0] TW_LOWER = 32'h7FFF_FFFF;
	localparam logic [31:0] TW_MULT = 32'd1812433253;
	localparam logic [31:0] TEMPER_B = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C = 32'hEFC6_0000;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] SPAN_IDX = IDX_W'(SHIFT_SPAN);
	localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(STATE_WORDS - SHIFT_SPAN);

	typedef enum logic {
		OP_RELOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL_MUL,
		ST_FILL_WR,
		ST_TW_RD0,
		ST_TW_RD1,
		ST_TW_RD2,
		ST_TW_WR,
		ST_RD,
		ST_TEMPER,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] add_span(input logic [IDX_W-1:0] i);
		return (i >= WRAP_IDX) ? i - WRAP_IDX : i + SPAN_IDX;
	endfunction
endpackage
`default_nettype wire

### sv/mtrr_ram.sv
// generic single-port ram with registered read
`default_nettype none
module mtrr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### sv/mtrr_divider.sv
// iterative 33-bit unsigned remainder, one bit per cycle
`default_nettype none
module mtrr_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [31:0] dividend,
	input wire logic [32:0] divisor,
	output logic done,
	output logic [31:0] remainder
);
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [32:0] den_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
			end
		end
	end

	assign remainder = rem_q[31:0];
endmodule
`default_nettype wire

### sv/mt19937_ranged_random.sv
// top level: ranged mt19937 generator with apb seed register
// An item is taken when start is high and busy is low; one result follows with a one-cycle
// done strobe that cannot be stalled. After reset the store is filled from seed zero, each
// word in a multiply step and a write step, with busy high and no result. A reload refills
// the store the same way from the seed register. A draw reads and tempers a word and waits on
// the bit-serial 32-step remainder unit; a draw at index zero first twists all 624 words, each
// with three reads and one write on a single-port store. An empty range skips straight to done.
`default_nettype none
module mt19937_ranged_random (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic op,
	input wire logic signed [31:0] low_bound,
	input wire logic signed [31:0] high_bound,
	output logic done,
	output logic signed [31:0] value,
	output logic status,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = mtrr_pkg::IDX_W;

	mtrr_pkg::state_t state_q, state_d;
	logic [31:0] seed_q;
	logic [IW-1:0] idx_q, k_q;
	logic [31:0] prev_q, mul_s1, y0_q, y1_q, lo_q;
	logic [32:0] span_q;
	logic boot_q;
	logic ram_we;
	logic [IW-1:0] ram_addr;
	logic [31:0] ram_wdata, ram_rdata;
	logic div_go, div_done;
	logic [31:0] div_rem;
	logic [31:0] tw_y, tw_w;

	assign pready = 1'b1;
	assign prdata = seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			seed_q <= pwdata;
		end
	end

	mtrr_ram #(.WIDTH(32), .DEPTH(mtrr_pkg::STATE_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	mtrr_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(mtrr_pkg::temper(ram_rdata)),
		.divisor(span_q), .done(div_done), .remainder(div_rem)
	);

	assign tw_y = (y0_q & mtrr_pkg::TW_UPPER) | (y1_q & mtrr_pkg::TW_LOWER);
	assign tw_w = ram_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? mtrr_pkg::TW_MATRIX : 32'h0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtrr_pkg::ST_IDLE: begin
				if (start) begin
					if (op == mtrr_pkg::OP_RELOAD) begin
						state_d = mtrr_pkg::ST_FILL_MUL;
					end else if (low_bound > high_bound) begin
						state_d = mtrr_pkg::ST_DONE;
					end else if (idx_q == '0) begin
						state_d = mtrr_pkg::ST_TW_RD0;
					end else begin
						state_d = mtrr_pkg::ST_RD;
					end
				end
			end
			mtrr_pkg::ST_FILL_MUL: state_d = mtrr_pkg::ST_FILL_WR;
			mtrr_pkg::ST_FILL_WR: begin
				if (k_q == mtrr_pkg::LAST_IDX) begin
					state_d = boot_q ? mtrr_pkg::ST_IDLE : mtrr_pkg::ST_DONE;
				end else begin
					state_d = mtrr_pkg::ST_FILL_MUL;
				end
			end
			mtrr_pkg::ST_TW_RD0: state_d = mtrr_pkg::ST_TW_RD1;
			mtrr_pkg::ST_TW_RD1: state_d = mtrr_pkg::ST_TW_RD2;
			mtrr_pkg::ST_TW_RD2: state_d = mtrr_pkg::ST_TW_WR;
			mtrr_pkg::ST_TW_WR:
				state_d = (k_q == mtrr_pkg::LAST_IDX) ? mtrr_pkg::ST_RD : mtrr_pkg::ST_TW_RD0;
			mtrr_pkg::ST_RD: state_d = mtrr_pkg::ST_TEMPER;
			mtrr_pkg::ST_TEMPER: state_d = mtrr_pkg::ST_DIV;
			mtrr_pkg::ST_DIV: if (div_done) state_d = mtrr_pkg::ST_DONE;
			mtrr_pkg::ST_DONE: state_d = mtrr_pkg::ST_IDLE;
			default: state_d = mtrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = k_q;
		ram_wdata = mul_s1 + 32'(k_q);
		div_go = 1'b0;
		unique case (state_q)
			mtrr_pkg::ST_FILL_WR: begin
				ram_we = 1'b1;
				ram_wdata = (k_q == '0) ? prev_q : mul_s1 + 32'(k_q);
			end
			mtrr_pkg::ST_TW_RD0: ram_addr = k_q;
			mtrr_pkg::ST_TW_RD1: ram_addr = mtrr_pkg::inc_wrap(k_q);
			mtrr_pkg::ST_TW_RD2: ram_addr = mtrr_pkg::add_span(k_q);
			mtrr_pkg::ST_TW_WR: begin
				ram_we = 1'b1;
				ram_wdata = tw_w;
			end
			mtrr_pkg::ST_RD: ram_addr = idx_q;
			mtrr_pkg::ST_TEMPER: div_go = 1'b0;
			mtrr_pkg::ST_DIV: div_go = 1'b0;
			default: ram_addr = k_q;
		endcase
		if (state_q == mtrr_pkg::ST_TEMPER) div_go = 1'b1;
	end

	assign busy = (state_q != mtrr_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtrr_pkg::ST_FILL_MUL;
			boot_q <= 1'b1;
			k_q <= '0;
			idx_q <= '0;
			prev_q <= '0;
			done <= 1'b0;
			status <= 1'b0;
			value <= '0;
		end else begin
			state_q <= state_d;
			done <= (state_q == mtrr_pkg::ST_DONE);
			unique case (state_q)
				mtrr_pkg::ST_IDLE: begin
					k_q <= '0;
					value <= '0;
					status <= start && op == mtrr_pkg::OP_DRAW && (low_bound > high_bound);
					if (start && op == mtrr_pkg::OP_RELOAD) begin
						prev_q <= seed_q;
						idx_q <= '0;
					end
				end
				mtrr_pkg::ST_FILL_WR: begin
					prev_q <= ram_wdata;
					k_q <= mtrr_pkg::inc_wrap(k_q);
					if (k_q == mtrr_pkg::LAST_IDX) boot_q <= 1'b0;
				end
				mtrr_pkg::ST_TW_WR: k_q <= mtrr_pkg::inc_wrap(k_q);
				mtrr_pkg::ST_DIV: begin
					if (div_done) begin
						value <= lo_q + div_rem;
						idx_q <= mtrr_pkg::inc_wrap(idx_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mtrr_pkg::TW_MULT * (prev_q ^ (prev_q >> 30));
		if (state_q == mtrr_pkg::ST_TW_RD1) y0_q <= ram_rdata;
		if (state_q == mtrr_pkg::ST_TW_RD2) y1_q <= ram_rdata;
		if (state_q == mtrr_pkg::ST_IDLE && start) begin
			lo_q <= low_bound;
			span_q <= 33'({high_bound[31], high_bound} - {low_bound[31], low_bound}) + 33'd1;
		end
	end
endmodule
`default_nettype wire
